### design/oprf_pkg.sv
// ----------------------------------------------------------------------------
// oprf_pkg
// Shared types and constants of the page-mode frame store with bus transfer
// generation: opcodes, controller command bytes, the command queue entry and
// the result word.
// ----------------------------------------------------------------------------
package oprf_pkg;

	// default geometry of the frame store
	localparam int PAGES_DEF   = 8;
	localparam int COLUMNS_DEF = 128;

	// field widths of a queued command (sized for up to 16 pages)
	localparam int PAGE_W = 4;
	localparam int ROW_W  = 7;

	// depth of the queue between front and back
	localparam int FIFO_DEPTH = 2;

	// controller command and control bytes
	localparam logic [7:0] CTRL_CMD      = 8'h80;
	localparam logic [7:0] PAGE_ADDR_CMD = 8'hB0;
	localparam logic [7:0] COL_HI_CMD    = 8'h10;
	localparam logic [7:0] COL_LO_MASK   = 8'h0F;
	localparam logic [7:0] CTRL_DATA     = 8'h40;
	localparam logic [7:0] CONTRAST_CMD  = 8'h81;

	typedef enum logic [1:0] {
		OP_DRAW       = 2'd0,
		OP_CLEAR_SEND = 2'd1,
		OP_SEND       = 2'd2,
		OP_CONTRAST   = 2'd3
	} opcode_t;

	// classified request as it travels through the queue
	typedef struct packed {
		opcode_t           kind;
		logic [PAGE_W-1:0] page;
		logic [ROW_W-1:0]  row_lo;
		logic [ROW_W-1:0]  row_hi;
		logic [6:0]        column;
		logic [7:0]        contrast;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        transfer_start;
		logic        transfer_end;
		logic        last;
	} word_t;

endpackage

### design/oprf_if.sv
// ----------------------------------------------------------------------------
// oprf_if
// Valid/ready channels of the frame store: the request channel and the
// transfer word channel.
// ----------------------------------------------------------------------------

// request channel
interface oprf_op_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [6:0] x_column;
	logic [5:0] y_start;
	logic [6:0] line_height;
	logic [2:0] page_index;
	logic [7:0] contrast_level;

	modport source (
		output valid, opcode, x_column, y_start, line_height, page_index, contrast_level,
		input  ready
	);
	modport sink (
		input  valid, opcode, x_column, y_start, line_height, page_index, contrast_level,
		output ready
	);
endinterface

// transfer word channel
interface oprf_xfer_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        transfer_start;
	logic        transfer_end;
	logic        last;

	modport source (
		output valid, data_word, byte_count, transfer_start, transfer_end, last,
		input  ready
	);
	modport sink (
		input  valid, data_word, byte_count, transfer_start, transfer_end, last,
		output ready
	);
endinterface

### design/oprf_front.sv
// ----------------------------------------------------------------------------
// oprf_front
// Accepts requests, clips line draws to the store, drops requests that
// produce nothing and registers the classified command for the queue.
// ----------------------------------------------------------------------------
module oprf_front #(
	parameter int PAGES   = oprf_pkg::PAGES_DEF,
	parameter int COLUMNS = oprf_pkg::COLUMNS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wipe_busy,
	oprf_op_if.sink       op_chan,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output oprf_pkg::cmd_t cmd
);

	localparam int         ROWS       = PAGES * 8;
	localparam logic [7:0] ROW_LIMIT  = 8'(ROWS);
	localparam logic [7:0] LAST_ROW   = 8'(ROWS - 1);
	localparam logic [8:0] COL_LIMIT  = 9'(COLUMNS);
	localparam logic [4:0] PAGE_LIMIT = 5'(PAGES);

	logic           accept;
	logic           keep;
	logic           draw_ok;
	logic           page_ok;
	logic [7:0]     row_end;
	logic [7:0]     row_top;
	logic [7:0]     row_clip;
	oprf_pkg::cmd_t cmd_n;
	logic           cmd_v_s1;
	oprf_pkg::cmd_t cmd_s1;

	assign op_chan.ready = !wipe_busy && (!cmd_v_s1 || cmd_ready);
	assign accept        = op_chan.valid && op_chan.ready;

	// line extent, clipped at the bottom row of the store
	always_comb begin
		row_end  = {2'b00, op_chan.y_start} + {1'b0, op_chan.line_height};
		row_top  = row_end - 8'd1;
		row_clip = (row_top > LAST_ROW) ? LAST_ROW : row_top;
		draw_ok  = ({2'b00, op_chan.x_column} < COL_LIMIT) && (op_chan.line_height != 7'd0)
			&& ({2'b00, op_chan.y_start} < ROW_LIMIT);
		page_ok  = {2'b00, op_chan.page_index} < PAGE_LIMIT;
	end

	// classify the request
	always_comb begin
		cmd_n.kind     = oprf_pkg::opcode_t'(op_chan.opcode);
		cmd_n.page     = {1'b0, op_chan.page_index};
		cmd_n.row_lo   = {1'b0, op_chan.y_start};
		cmd_n.row_hi   = row_clip[6:0];
		cmd_n.column   = op_chan.x_column;
		cmd_n.contrast = op_chan.contrast_level;
		case (oprf_pkg::opcode_t'(op_chan.opcode))
			oprf_pkg::OP_DRAW:       keep = draw_ok;
			oprf_pkg::OP_CLEAR_SEND: keep = page_ok;
			oprf_pkg::OP_SEND:       keep = page_ok;
			oprf_pkg::OP_CONTRAST:   keep = 1'b1;
			default:                 keep = 1'b0;
		endcase
	end

	// command register toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else if (accept) begin
			cmd_v_s1 <= keep;
		end else if (cmd_ready) begin
			cmd_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_n;
		end
	end

	assign cmd_valid = cmd_v_s1;
	assign cmd       = cmd_s1;

endmodule

### design/oprf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// oprf_cmd_fifo
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module oprf_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  oprf_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output oprf_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = $clog2(oprf_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(oprf_pkg::FIFO_DEPTH + 1);

	oprf_pkg::cmd_t    entry_q [oprf_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(oprf_pkg::FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### design/oprf_back.sv
// ----------------------------------------------------------------------------
// oprf_back
// Executes queued commands on the frame store, held as one 64-bit row of
// eight column bytes per entry: clearing pass after reset, read-modify-write
// line draws, page sends and the contrast command, with an output register.
// ----------------------------------------------------------------------------
module oprf_back #(
	parameter int PAGES   = oprf_pkg::PAGES_DEF,
	parameter int COLUMNS = oprf_pkg::COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [2:0]     cfg_wr_data,
	output logic           wipe_busy,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  oprf_pkg::cmd_t cmd,
	oprf_xfer_if.source    xfer_chan
);

	localparam int RW     = (COLUMNS + 7) / 8;
	localparam int DW     = COLUMNS / 8 + 1;
	localparam int LAST_N = COLUMNS + 1 - 8 * (DW - 1);
	localparam int DEPTH  = PAGES * RW;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RWW    = (RW > 1) ? $clog2(RW) : 1;
	localparam int JW     = $clog2(DW);
	localparam int PW     = oprf_pkg::PAGE_W;

	localparam logic [JW-1:0]  LAST_J    = JW'(DW - 1);
	localparam logic [RWW-1:0] LAST_RIDX = RWW'(RW - 1);
	localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [3:0]     LAST_CNT  = 4'(LAST_N);

	typedef enum logic [6:0] {
		ST_WIPE  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_PAGE  = 7'b0000100,
		ST_COLM  = 7'b0001000,
		ST_DATA  = 7'b0010000,
		ST_DRAW  = 7'b0100000,
		ST_CONTR = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	oprf_pkg::cmd_t    cur_q, cur_d;
	logic [PW-1:0]     pg_q, pg_d;
	logic [JW-1:0]     j_q, j_d;
	logic [7:0]        prev_q;
	logic [AW-1:0]     wipe_q;
	logic [2:0]        offset_q;
	logic [63:0]       rd_q;
	logic              out_v_q;
	oprf_pkg::word_t   out_q;
	logic [63:0]       mem [DEPTH];

	logic              ld;
	logic              word_ld;
	oprf_pkg::word_t   word_n;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [63:0]       wdata;
	logic [AW-1:0]     rd_addr;
	logic              clr;
	logic [7:0]        mask;
	logic [63:0]       lane_mask;
	logic [63:0]       data_bytes;
	logic [3:0]        data_cnt;
	logic [7:0]        off8;

	function automatic logic [AW-1:0] row_addr(input logic [PW-1:0] pg,
			input logic [RWW-1:0] rw);
		row_addr = AW'(32'(pg) * RW + 32'(rw));
	endfunction

	function automatic logic [RWW-1:0] data_row(input logic [JW-1:0] j);
		data_row = (32'(j) < RW) ? RWW'(j) : LAST_RIDX;
	endfunction

	function automatic logic [RWW-1:0] col_row(input logic [6:0] col);
		col_row = RWW'(col[6:3]);
	endfunction

	assign ld        = !out_v_q || xfer_chan.ready;
	assign clr       = cur_q.kind == oprf_pkg::OP_CLEAR_SEND;
	assign wipe_busy = state_q == ST_WIPE;
	assign cmd_ready = state_q == ST_IDLE;
	assign off8      = {5'd0, offset_q};

	// pixel mask of the current page for a line draw
	always_comb begin
		for (int r = 0; r < 8; r++) begin
			mask[r] = ({pg_q, 3'(r)} >= cur_q.row_lo) && ({pg_q, 3'(r)} <= cur_q.row_hi);
		end
		lane_mask = 64'(mask) << {cur_q.column[2:0], 3'b000};
	end

	// data word: control byte or carried byte, then seven bytes of the row
	always_comb begin
		logic [7:0] b;
		data_cnt   = (j_q == LAST_J) ? LAST_CNT : 4'd8;
		data_bytes = '0;
		for (int k = 0; k < 8; k++) begin
			if (k == 0) begin
				b = (j_q == '0) ? oprf_pkg::CTRL_DATA : (clr ? 8'd0 : prev_q);
			end else begin
				b = clr ? 8'd0 : rd_q[8*(k-1) +: 8];
			end
			if (4'(k) < data_cnt) begin
				data_bytes[8*k +: 8] = b;
			end
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		pg_d    = pg_q;
		j_d     = j_q;
		word_ld = 1'b0;
		word_n  = '0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		case (state_q)
			ST_WIPE: begin
				we    = 1'b1;
				waddr = wipe_q;
				if (wipe_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cur_d = cmd;
					j_d   = '0;
					case (cmd.kind)
						oprf_pkg::OP_DRAW: begin
							pg_d    = cmd.row_lo[6:3];
							state_d = ST_DRAW;
						end
						oprf_pkg::OP_CLEAR_SEND, oprf_pkg::OP_SEND: begin
							pg_d    = cmd.page;
							state_d = ST_PAGE;
						end
						oprf_pkg::OP_CONTRAST: state_d = ST_CONTR;
						default:               state_d = ST_IDLE;
					endcase
				end
			end
			ST_PAGE: begin
				if (ld) begin
					word_ld               = 1'b1;
					word_n.data_word      = {48'd0, oprf_pkg::PAGE_ADDR_CMD | {4'd0, pg_q},
						oprf_pkg::CTRL_CMD};
					word_n.byte_count     = 4'd2;
					word_n.transfer_start = 1'b1;
					word_n.transfer_end   = 1'b1;
					state_d               = ST_COLM;
				end
			end
			ST_COLM: begin
				if (ld) begin
					word_ld               = 1'b1;
					word_n.data_word      = {32'd0, off8 & oprf_pkg::COL_LO_MASK,
						oprf_pkg::CTRL_CMD, oprf_pkg::COL_HI_CMD | {4'd0, off8[7:4]},
						oprf_pkg::CTRL_CMD};
					word_n.byte_count     = 4'd4;
					word_n.transfer_start = 1'b1;
					word_n.transfer_end   = 1'b1;
					state_d               = ST_DATA;
				end
			end
			ST_DATA: begin
				if (ld) begin
					word_ld               = 1'b1;
					word_n.data_word      = data_bytes;
					word_n.byte_count     = data_cnt;
					word_n.transfer_start = j_q == '0;
					word_n.transfer_end   = j_q == LAST_J;
					word_n.last           = j_q == LAST_J;
					// clear and send zeroes each row as it goes out
					if (clr && (32'(j_q) < RW)) begin
						we    = 1'b1;
						waddr = row_addr(pg_q, RWW'(j_q));
					end
					if (j_q == LAST_J) begin
						state_d = ST_IDLE;
					end else begin
						j_d = JW'(j_q + 1'b1);
					end
				end
			end
			ST_DRAW: begin
				we    = 1'b1;
				waddr = row_addr(pg_q, col_row(cur_q.column));
				wdata = rd_q | lane_mask;
				if (pg_q == cur_q.row_hi[6:3]) begin
					state_d = ST_IDLE;
				end else begin
					pg_d = PW'(pg_q + 1'b1);
				end
			end
			ST_CONTR: begin
				if (ld) begin
					word_ld               = 1'b1;
					word_n.data_word      = {40'd0, cur_q.contrast, oprf_pkg::CONTRAST_CMD,
						oprf_pkg::CTRL_CMD};
					word_n.byte_count     = 4'd3;
					word_n.transfer_start = 1'b1;
					word_n.transfer_end   = 1'b1;
					word_n.last           = 1'b1;
					state_d               = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read the row that the next cycle works on
	assign rd_addr = row_addr(pg_d, (state_d == ST_DRAW) ? col_row(cur_d.column) : data_row(j_d));

	// control state, column offset register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WIPE;
			wipe_q   <= '0;
			offset_q <= 3'd2;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WIPE) begin
				wipe_q <= AW'(wipe_q + 1'b1);
			end
			if (cfg_wr_en) begin
				offset_q <= cfg_wr_data;
			end
			if (word_ld) begin
				out_v_q <= 1'b1;
			end else if (xfer_chan.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// working registers and output word
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		pg_q  <= pg_d;
		j_q   <= j_d;
		if (word_ld) begin
			out_q <= word_n;
		end
		if (word_ld && state_q == ST_DATA) begin
			prev_q <= rd_q[63:56];
		end
	end

	// frame store rows
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	assign xfer_chan.valid          = out_v_q;
	assign xfer_chan.data_word      = out_q.data_word;
	assign xfer_chan.byte_count     = out_q.byte_count;
	assign xfer_chan.transfer_start = out_q.transfer_start;
	assign xfer_chan.transfer_end   = out_q.transfer_end;
	assign xfer_chan.last           = out_q.last;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.byte_count != 4'd0) && (out_q.byte_count <= 4'd8))
		else $error("result word byte count out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.last) |-> out_q.transfer_end)
		else $error("final word does not end its transfer");

	a_word_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (j_q <= LAST_J))
		else $error("data word index past end of page");

	a_wipe_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WIPE) |=> (state_q != ST_WIPE))
		else $error("clearing pass restarted without reset");

endmodule

### design/oled_page_buffer_refresh.sv
// ----------------------------------------------------------------------------
// oled_page_buffer_refresh
// Monochrome page-mode frame store with line drawing, page clear and send,
// and contrast command generation as packed 8-byte bus transfer words.
//
//   channel     dir   handshake      carries
//   op_chan     in    valid/ready    opcode, x_column, y_start, line_height,
//                                    page_index, contrast_level
//   xfer_chan   out   valid/ready    data_word, byte_count, transfer_start,
//                                    transfer_end, last
//   cfg_wr_*    in    write enable   column_offset (3 bits)
//
// A page send gives 2 + COLUMNS/8 + 1 words (19 by default) at one word per
// cycle while xfer_chan takes them, with one 64-bit frame row read per word;
// the back accepts each command only in its idle state. A line draw does one
// read-modify-write per touched page (1 to PAGES); a contrast request gives
// one word. After reset a clearing pass over PAGES*ceil(COLUMNS/8) rows
// (128 by default) zeroes the store, with op_chan ready held low.
// A stalled xfer_chan holds its word; the front and a two-entry queue keep
// taking requests until the queue fills.
// ----------------------------------------------------------------------------
module oled_page_buffer_refresh #(
	parameter int PAGES   = oprf_pkg::PAGES_DEF,
	parameter int COLUMNS = oprf_pkg::COLUMNS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_wr_data,
	oprf_op_if.sink      op_chan,
	oprf_xfer_if.source  xfer_chan
);

	logic           wipe_busy;
	logic           front_valid;
	logic           front_ready;
	oprf_pkg::cmd_t front_cmd;
	logic           queue_valid;
	logic           queue_ready;
	oprf_pkg::cmd_t queue_cmd;

	// request intake and classification
	oprf_front #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wipe_busy (wipe_busy),
		.op_chan   (op_chan),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	// command queue
	oprf_cmd_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_cmd    (queue_cmd)
	);

	// frame store and transfer generation
	oprf_back #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.wipe_busy   (wipe_busy),
		.cmd_valid   (queue_valid),
		.cmd_ready   (queue_ready),
		.cmd         (queue_cmd),
		.xfer_chan   (xfer_chan)
	);

endmodule

### tb/tb_oled_page_buffer_refresh.sv
// ----------------------------------------------------------------------------
// tb_oled_page_buffer_refresh
// Self-checking bench for the page-mode frame store. Requests go in on the
// op channel and a local model of the store predicts every transfer word.
// Each word taken from the transfer channel is compared field by field.
// Both channels idle at random. One receiver hold-off fills the block up,
// and the column offset register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_oled_page_buffer_refresh;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES       = oprf_pkg::PAGES_DEF;
	localparam int COLUMNS     = oprf_pkg::COLUMNS_DEF;
	localparam int ROWS        = PAGES * 8;
	localparam int DATA_BYTES  = COLUMNS + 1;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PRINT_MAX   = 40;

	// one request as the bench sees it
	typedef struct {
		oprf_pkg::opcode_t op;
		logic [6:0]        x;
		logic [5:0]        y;
		logic [6:0]        h;
		logic [2:0]        page;
		logic [7:0]        contrast;
	} op_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en;
	logic [2:0] cfg_wr_data;

	oprf_op_if   op_bus ();
	oprf_xfer_if xfer_bus ();

	oled_page_buffer_refresh dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op_chan     (op_bus),
		.xfer_chan   (xfer_bus)
	);

	// local copy of the store and the register
	logic [7:0]      frame_model [PAGES][COLUMNS];
	logic [2:0]      offset_model;
	oprf_pkg::word_t expected_words [$];

	int  errors = 0;
	int  cycle_count = 0;
	bit  free_run = 1'b0;
	int  rx_hold_req = 0;
	int  rx_hold_left = 0;
	int  rx_stall_left = 0;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, expected_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report(input string msg);
		if (errors < PRINT_MAX)
			$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic op_req_t make_req(oprf_pkg::opcode_t op, int x, int y, int h,
			int page, int contrast);
		op_req_t r;
		r.op       = op;
		r.x        = 7'(x);
		r.y        = 6'(y);
		r.h        = 7'(h);
		r.page     = 3'(page);
		r.contrast = 8'(contrast);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// prediction of transfer words
	// ------------------------------------------------------------------------
	task automatic queue_word(input logic [63:0] data, input int count, input bit first_w,
			input bit close_w, input bit final_w);
		oprf_pkg::word_t w;
		w.data_word      = data;
		w.byte_count     = 4'(count);
		w.transfer_start = first_w;
		w.transfer_end   = close_w;
		w.last           = final_w;
		expected_words.push_back(w);
	endtask

	task automatic queue_page(input logic [2:0] page);
		logic [7:0]  bytes [DATA_BYTES];
		logic [7:0]  col;
		logic [63:0] data;
		int          pos;
		int          n;
		col = {5'b0, offset_model};
		// page address command
		queue_word({48'h0, oprf_pkg::PAGE_ADDR_CMD | {5'b0, page}, oprf_pkg::CTRL_CMD},
			2, 1'b1, 1'b1, 1'b0);
		// column address command
		queue_word({32'h0, col & oprf_pkg::COL_LO_MASK, oprf_pkg::CTRL_CMD,
			oprf_pkg::COL_HI_CMD | (col >> 4), oprf_pkg::CTRL_CMD}, 4, 1'b1, 1'b1, 1'b0);
		// data transfer: control byte then the page bytes
		bytes[0] = oprf_pkg::CTRL_DATA;
		for (int c = 0; c < COLUMNS; c++)
			bytes[c + 1] = frame_model[page][c];
		pos = 0;
		while (pos < DATA_BYTES) begin
			n = (DATA_BYTES - pos > 8) ? 8 : DATA_BYTES - pos;
			data = '0;
			for (int b = 0; b < n; b++)
				data[8*b +: 8] = bytes[pos + b];
			queue_word(data, n, pos == 0, pos + n >= DATA_BYTES, pos + n >= DATA_BYTES);
			pos += n;
		end
	endtask

	task automatic predict_transfers(input op_req_t r);
		int row;
		case (r.op)
			oprf_pkg::OP_DRAW: begin
				if (r.x < COLUMNS) begin
					for (int i = 0; i < r.h; i++) begin
						row = r.y + i;
						if (row >= ROWS)
							break;
						frame_model[row / 8][r.x][row % 8] = 1'b1;
					end
				end
			end
			oprf_pkg::OP_CLEAR_SEND, oprf_pkg::OP_SEND: begin
				if (r.page < PAGES) begin
					if (r.op == oprf_pkg::OP_CLEAR_SEND)
						for (int c = 0; c < COLUMNS; c++)
							frame_model[r.page][c] = 8'h00;
					queue_page(r.page);
				end
			end
			default: begin
				queue_word({40'h0, r.contrast, oprf_pkg::CONTRAST_CMD, oprf_pkg::CTRL_CMD},
					3, 1'b1, 1'b1, 1'b1);
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	task automatic send_request(input op_req_t r);
		int gap;
		gap = (!free_run && $urandom_range(0, 99) < 35) ? idle_len() : 0;
		if (gap > 0) begin
			op_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op_bus.opcode         = r.op;
		op_bus.x_column       = r.x;
		op_bus.y_start        = r.y;
		op_bus.line_height    = r.h;
		op_bus.page_index     = r.page;
		op_bus.contrast_level = r.contrast;
		op_bus.valid          = 1'b1;
		@(posedge clk);
		while (!op_bus.ready)
			@(posedge clk);
		predict_transfers(r);
		@(negedge clk);
	endtask

	// stop offering and let every expected word come out
	task automatic drain();
		op_bus.valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_column_offset(input logic [2:0] value);
		drain();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en    = 1'b0;
		offset_model = value;
	endtask

	function automatic op_req_t random_request();
		op_req_t r;
		int      sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			r.op = oprf_pkg::OP_DRAW;
		else if (sel < 68)
			r.op = oprf_pkg::OP_SEND;
		else if (sel < 78)
			r.op = oprf_pkg::OP_CLEAR_SEND;
		else
			r.op = oprf_pkg::OP_CONTRAST;
		r.x        = 7'($urandom_range(0, 127));
		r.y        = 6'($urandom_range(0, 63));
		r.page     = 3'($urandom_range(0, 7));
		r.contrast = 8'($urandom_range(0, 255));
		// line heights: mostly short, some zero, some past the bottom
		case ($urandom_range(0, 9))
			0:       r.h = 7'd0;
			1, 2:    r.h = 7'($urandom_range(64, 127));
			default: r.h = 7'($urandom_range(1, 16));
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// transfer side: ready pattern and word check
	// ------------------------------------------------------------------------
	task automatic check_word();
		oprf_pkg::word_t want;
		if (expected_words.size() == 0) begin
			report($sformatf("unexpected word %h", xfer_bus.data_word));
			return;
		end
		want = expected_words.pop_front();
		if (xfer_bus.data_word !== want.data_word)
			report($sformatf("data_word got %h want %h", xfer_bus.data_word, want.data_word));
		if (xfer_bus.byte_count !== want.byte_count)
			report($sformatf("byte_count got %0d want %0d (word %h)", xfer_bus.byte_count,
				want.byte_count, want.data_word));
		if (xfer_bus.transfer_start !== want.transfer_start)
			report($sformatf("transfer_start got %b want %b (word %h)",
				xfer_bus.transfer_start, want.transfer_start, want.data_word));
		if (xfer_bus.transfer_end !== want.transfer_end)
			report($sformatf("transfer_end got %b want %b (word %h)",
				xfer_bus.transfer_end, want.transfer_end, want.data_word));
		if (xfer_bus.last !== want.last)
			report($sformatf("last got %b want %b (word %h)", xfer_bus.last, want.last,
				want.data_word));
	endtask

	initial begin
		xfer_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				rx_hold_left = rx_hold_req;
				rx_hold_req  = 0;
			end
			if (rx_hold_left > 0) begin
				xfer_bus.ready = 1'b0;
				rx_hold_left--;
			end else if (rx_stall_left > 0) begin
				xfer_bus.ready = 1'b0;
				rx_stall_left--;
			end else if (!free_run && $urandom_range(0, 99) < 30) begin
				xfer_bus.ready = 1'b0;
				rx_stall_left  = idle_len() - 1;
			end else begin
				xfer_bus.ready = 1'b1;
			end
			@(posedge clk);
			if (arst_n && xfer_bus.valid && xfer_bus.ready)
				check_word();
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// store is blank after reset; contrast extremes
	task automatic test_reset_contents();
		send_request(make_req(oprf_pkg::OP_SEND, $urandom_range(0, 127),
			$urandom_range(0, 63), $urandom_range(0, 127), 0, $urandom_range(0, 255)));
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 7, 0));
		send_request(make_req(oprf_pkg::OP_CONTRAST, 127, 63, 127, 7, 0));
		send_request(make_req(oprf_pkg::OP_CONTRAST, 0, 0, 0, 0, 255));
	endtask

	// full column, clipping, zero height, page crossing, clear
	task automatic test_line_draw();
		send_request(make_req(oprf_pkg::OP_DRAW, 0, 0, 64, 5, 8'hA5));
		send_request(make_req(oprf_pkg::OP_DRAW, 127, 63, 127, 2, 8'h5A));
		send_request(make_req(oprf_pkg::OP_DRAW, 5, 10, 0, 0, 0));
		send_request(make_req(oprf_pkg::OP_DRAW, 64, 7, 2, 7, 255));
		send_request(make_req(oprf_pkg::OP_DRAW, 127, 56, 8, 0, 0));
		send_request(make_req(oprf_pkg::OP_DRAW, 3, 60, 64, 3, 1));
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 0, 0));
		send_request(make_req(oprf_pkg::OP_SEND, 127, 63, 127, 7, 255));
		send_request(make_req(oprf_pkg::OP_CLEAR_SEND, 0, 0, 0, 0, 0));
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 0, 0));
		send_request(make_req(oprf_pkg::OP_SEND, 64, 0, 0, 1, 0));
	endtask

	// column offset of zero and of four
	task automatic test_column_offset();
		set_column_offset(3'd0);
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 1, 0));
		set_column_offset(3'd4);
		send_request(make_req(oprf_pkg::OP_CLEAR_SEND, 0, 0, 0, 7, 0));
	endtask

	// long receiver hold-off with requests still offered, then a full pause
	task automatic test_backpressure();
		free_run    = 1'b1;
		rx_hold_req = 300;
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 2, 0));
		send_request(make_req(oprf_pkg::OP_DRAW, 20, 14, 5, 0, 0));
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 1, 0));
		send_request(make_req(oprf_pkg::OP_DRAW, 21, 0, 64, 0, 0));
		send_request(make_req(oprf_pkg::OP_CONTRAST, 0, 0, 0, 0, 8'h3C));
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 2, 0));
		send_request(make_req(oprf_pkg::OP_CLEAR_SEND, 0, 0, 0, 0, 0));
		free_run = 1'b0;
		// sender waits for every word before going on
		drain();
		send_request(make_req(oprf_pkg::OP_SEND, 0, 0, 0, 0, 0));
	endtask

	// random requests in phases with differing offset and pacing
	task automatic test_random();
		for (int phase = 0; phase < 5; phase++) begin
			set_column_offset(3'($urandom_range(0, 4)));
			free_run = (phase == 2);
			for (int i = 0; i < 47; i++)
				send_request(random_request());
		end
		free_run = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		op_bus.valid          = 1'b0;
		op_bus.opcode         = oprf_pkg::OP_DRAW;
		op_bus.x_column       = '0;
		op_bus.y_start        = '0;
		op_bus.line_height    = '0;
		op_bus.page_index     = '0;
		op_bus.contrast_level = '0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		offset_model          = 3'd2;
		for (int p = 0; p < PAGES; p++)
			for (int c = 0; c < COLUMNS; c++)
				frame_model[p][c] = 8'h00;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_line_draw();
		test_column_offset();
		test_backpressure();
		test_random();

		// wait for the last words, then a quiet stretch
		op_bus.valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/oprf_pkg.sv
design/oprf_if.sv
design/oprf_front.sv
design/oprf_cmd_fifo.sv
design/oprf_back.sv
design/oled_page_buffer_refresh.sv
tb/tb_oled_page_buffer_refresh.sv
